// ===== sv/fenwick_dominance_rank_counter_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion helpers for the Fenwick dominance rank counter.
// Both macros sample on i_clk and are switched off while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef FENWICK_DOMINANCE_RANK_COUNTER_MACROS_SVH
`define FENWICK_DOMINANCE_RANK_COUNTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FDRC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FDRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fdrc_pkg.sv =====
// ---------------------------------------------------------------------------
// fdrc_pkg
// Shared types and constants of the Fenwick dominance rank counter.
// ---------------------------------------------------------------------------
package fdrc_pkg;

    // Field widths of the request and result items
    localparam int X_W       = 10;
    localparam int LVL_W     = 10;
    localparam int CNT_OUT_W = 11;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic       CFG_IDX_MAX_X = 1'b0;
    localparam logic [X_W-1:0] MAX_X_RESET = 10'd1023;

    // Request action codes
    localparam logic ACT_PLACE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUERY,
        S_HIST_RD,
        S_HIST_WR,
        S_UPDATE,
        S_LOOKUP,
        S_DONE
    } t_state;

    // One result item
    typedef struct packed {
        logic [LVL_W-1:0]     star_level;
        logic [CNT_OUT_W-1:0] level_count;
        logic                 error;
    } t_result;

endpackage

// ===== sv/fdrc_req_if.sv =====
// ---------------------------------------------------------------------------
// fdrc_req_if
// Request channel: one star placement or one histogram read per request.
// ---------------------------------------------------------------------------
interface fdrc_req_if import fdrc_pkg::*; ();

    logic             valid;
    logic             ready;
    logic             action;
    logic [X_W-1:0]   x_coord;
    logic [LVL_W-1:0] level_index;

    modport source (output valid, output action, output x_coord, output level_index,
                    input ready);
    modport sink   (input valid, input action, input x_coord, input level_index,
                    output ready);

endinterface

// ===== sv/fdrc_rsp_if.sv =====
// ---------------------------------------------------------------------------
// fdrc_rsp_if
// Result channel: star level, histogram count and error flag per request.
// ---------------------------------------------------------------------------
interface fdrc_rsp_if import fdrc_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [LVL_W-1:0]     star_level;
    logic [CNT_OUT_W-1:0] level_count;
    logic                 error;

    modport source (output valid, output star_level, output level_count, output error,
                    input ready);
    modport sink   (input valid, input star_level, input level_count, input error,
                    output ready);

endinterface

// ===== sv/fdrc_ram.sv =====
// ---------------------------------------------------------------------------
// fdrc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module fdrc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/fdrc_cfg.sv =====
// ---------------------------------------------------------------------------
// fdrc_cfg
// APB register slice holding the largest accepted x coordinate.
// ---------------------------------------------------------------------------
module fdrc_cfg import fdrc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [X_W-1:0]     o_max_x
);

    logic [X_W-1:0] r_max_x;
    logic           wr_hit;

    // Decode the register index from the word address
    assign wr_hit = psel && penable && pwrite && (paddr[2] == CFG_IDX_MAX_X);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_x <= MAX_X_RESET;
        end else if (wr_hit) begin
            r_max_x <= pwdata[X_W-1:0];
        end
    end

    // Read back; unmapped words read as zero
    always_comb begin
        if (paddr[2] == CFG_IDX_MAX_X) begin
            prdata = {{(PDATA_W-X_W){1'b0}}, r_max_x};
        end else begin
            prdata = '0;
        end
    end

    assign pready  = 1'b1;
    assign o_max_x = r_max_x;

endmodule

// ===== sv/fdrc_ctrl.sv =====
// ---------------------------------------------------------------------------
// fdrc_ctrl
// Sequencer around the count tree RAM and the level histogram RAM: clear
// sweep, prefix walk, histogram bump, pipelined tree update walk and histogram read.
// ---------------------------------------------------------------------------
`include "fenwick_dominance_rank_counter_macros.svh"

module fdrc_ctrl import fdrc_pkg::*; #(
    parameter int X_RANGE   = 1024,
    parameter int MAX_STARS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_action,
    input  logic [X_W-1:0]   i_x_coord,
    input  logic [LVL_W-1:0] i_level_index,
    input  logic [X_W-1:0]   i_max_x,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_result          o_res
);

    // Only x below 2**X_W can ever be placed, only levels below 2**LVL_W read
    localparam int XMAX_CAP   = (X_RANGE > (1 << X_W)) ? ((1 << X_W) - 1) : (X_RANGE - 1);
    localparam int TREE_DEPTH = XMAX_CAP + 1;
    localparam int HIST_DEPTH = (MAX_STARS > (1 << LVL_W)) ? (1 << LVL_W) : MAX_STARS;
    localparam int TA_W       = $clog2(TREE_DEPTH);
    localparam int HA_W       = $clog2(HIST_DEPTH);
    localparam int PW         = TA_W + 2;
    localparam int CNT_W      = $clog2(MAX_STARS + 1);
    localparam int CLR_DEPTH  = (TREE_DEPTH > HIST_DEPTH) ? TREE_DEPTH : HIST_DEPTH;
    localparam int CLR_W      = $clog2(CLR_DEPTH);
    localparam logic [X_W-1:0] XMAX_CAP_V = X_W'(XMAX_CAP);

    t_state            r_state, n_state;
    logic [PW-1:0]     r_pos, n_pos;
    logic [PW-1:0]     r_start, n_start;
    logic [PW-1:0]     r_limit, n_limit;
    logic [CNT_W-1:0]  r_sum, n_sum;
    logic              r_rd_pend, n_rd_pend;
    logic [TA_W-1:0]   r_wa, n_wa;
    logic              r_hit, n_hit;
    logic [CNT_W-1:0]  r_placed, n_placed;
    logic [CLR_W-1:0]  r_clr, n_clr;
    t_result           r_res, n_res;

    logic              tree_we, tree_re;
    logic [TA_W-1:0]   tree_wa, tree_ra;
    logic [CNT_W-1:0]  tree_wd, tree_rdata;
    logic              hist_we, hist_re;
    logic [HA_W-1:0]   hist_wa, hist_ra;
    logic [CNT_W-1:0]  hist_wd, hist_rdata;

    logic [X_W-1:0]    m_eff;
    logic              x_bad, cap_full, idx_in_range, sum_in_hist, up_ok;
    logic              clr_in_tree, clr_in_hist;
    logic [PW-1:0]     pos_low;

    // Count tree, one entry per position 1..TREE_DEPTH at address pos-1
    fdrc_ram #(.DEPTH(TREE_DEPTH), .WIDTH(CNT_W)) u_tree (
        .i_clk   (i_clk),
        .i_we    (tree_we),
        .i_waddr (tree_wa),
        .i_wdata (tree_wd),
        .i_re    (tree_re),
        .i_raddr (tree_ra),
        .o_rdata (tree_rdata)
    );

    // Level histogram
    fdrc_ram #(.DEPTH(HIST_DEPTH), .WIDTH(CNT_W)) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_wa),
        .i_wdata (hist_wd),
        .i_re    (hist_re),
        .i_raddr (hist_ra),
        .o_rdata (hist_rdata)
    );

    // Request checks
    assign m_eff        = (i_max_x > XMAX_CAP_V) ? XMAX_CAP_V : i_max_x;
    assign x_bad        = (i_x_coord > m_eff);
    assign cap_full     = (r_placed == CNT_W'(MAX_STARS));
    assign idx_in_range = ({1'b0, i_level_index} < (LVL_W+1)'(HIST_DEPTH));
    assign sum_in_hist  = (r_sum < CNT_W'(HIST_DEPTH));
    assign up_ok        = (r_pos <= r_limit);
    assign pos_low      = r_pos & (~r_pos + PW'(1));
    assign clr_in_tree  = ({1'b0, r_clr} < (CLR_W+1)'(TREE_DEPTH));
    assign clr_in_hist  = ({1'b0, r_clr} < (CLR_W+1)'(HIST_DEPTH));

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_placed  <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_placed  <= n_placed;
            r_rd_pend <= n_rd_pend;
        end
    end

    // Walk and result payload
    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_start <= n_start;
        r_limit <= n_limit;
        r_sum   <= n_sum;
        r_wa    <= n_wa;
        r_hit   <= n_hit;
        r_res   <= n_res;
    end

    // Next state and memory controls
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_start   = r_start;
        n_limit   = r_limit;
        n_sum     = r_sum;
        n_rd_pend = 1'b0;
        n_wa      = r_wa;
        n_hit     = r_hit;
        n_placed  = r_placed;
        n_clr     = r_clr;
        n_res     = r_res;
        tree_we   = 1'b0;
        tree_wa   = '0;
        tree_wd   = '0;
        tree_re   = 1'b0;
        tree_ra   = '0;
        hist_we   = 1'b0;
        hist_wa   = '0;
        hist_wd   = '0;
        hist_re   = 1'b0;
        hist_ra   = '0;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            // Sweep both RAMs to zero, one address per cycle
            S_CLEAR: begin
                tree_we = clr_in_tree;
                tree_wa = r_clr[TA_W-1:0];
                hist_we = clr_in_hist;
                hist_wa = r_clr[HA_W-1:0];
                n_clr   = r_clr + CLR_W'(1);
                if (r_clr == CLR_W'(CLR_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // Take a request and dispatch it
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_action == ACT_READ) begin
                        n_hit   = idx_in_range;
                        hist_re = idx_in_range;
                        hist_ra = i_level_index[HA_W-1:0];
                        n_state = S_LOOKUP;
                    end else if (x_bad || cap_full) begin
                        n_res.star_level  = '0;
                        n_res.level_count = '0;
                        n_res.error       = 1'b1;
                        n_state           = S_DONE;
                    end else begin
                        n_pos   = PW'(i_x_coord) + PW'(1);
                        n_start = PW'(i_x_coord) + PW'(1);
                        n_limit = PW'(m_eff) + PW'(1);
                        n_sum   = '0;
                        n_state = S_QUERY;
                    end
                end
            end

            // Prefix walk: issue a read per cycle, add its data in the cycle after
            S_QUERY: begin
                if (r_pos != '0) begin
                    tree_re   = 1'b1;
                    tree_ra   = TA_W'(r_pos - PW'(1));
                    n_pos     = r_pos - pos_low;
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) begin
                    n_sum = r_sum + tree_rdata;
                end
                if (r_pos == '0) begin
                    n_state = S_HIST_RD;
                end
            end

            // Fetch the histogram entry for this level
            S_HIST_RD: begin
                n_hit   = sum_in_hist;
                hist_re = sum_in_hist;
                hist_ra = HA_W'(r_sum);
                n_state = S_HIST_WR;
            end

            // Bump the histogram entry and start the update walk
            S_HIST_WR: begin
                hist_we = r_hit;
                hist_wa = HA_W'(r_sum);
                hist_wd = hist_rdata + CNT_W'(1);
                n_pos   = r_start;
                n_state = S_UPDATE;
            end

            // Update walk: read one position while writing back the previous one
            S_UPDATE: begin
                if (up_ok) begin
                    tree_re   = 1'b1;
                    tree_ra   = TA_W'(r_pos - PW'(1));
                    n_wa      = TA_W'(r_pos - PW'(1));
                    n_pos     = r_pos + pos_low;
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) begin
                    tree_we = 1'b1;
                    tree_wa = r_wa;
                    tree_wd = tree_rdata + CNT_W'(1);
                end
                if (!up_ok) begin
                    n_placed          = r_placed + CNT_W'(1);
                    n_res.star_level  = LVL_W'(r_sum);
                    n_res.level_count = '0;
                    n_res.error       = 1'b0;
                    n_state           = S_DONE;
                end
            end

            // Capture the histogram read
            S_LOOKUP: begin
                n_res.star_level  = '0;
                n_res.level_count = r_hit ? CNT_OUT_W'(hist_rdata) : '0;
                n_res.error       = 1'b0;
                n_state           = S_DONE;
            end

            // Hand the result to the output register
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_res = r_res;

    // Checks
    `FDRC_ASSERT_SAME(a_tree_rw_distinct, tree_we && tree_re, tree_wa != tree_ra, "tree read and write collide on one entry")
    `FDRC_ASSERT_SAME(a_placed_bound, 1'b1, r_placed <= CNT_W'(MAX_STARS), "star count exceeds capacity")
    `FDRC_ASSERT_NEXT(a_query_descends, (r_state == S_QUERY) && (r_pos != '0), r_pos < $past(r_pos), "prefix walk does not descend")
    `FDRC_ASSERT_NEXT(a_accept_leaves_idle, i_in_valid && o_in_ready, r_state != S_IDLE, "accepted request left sequencer idle")

endmodule

// ===== sv/fenwick_dominance_rank_counter.sv =====
// ---------------------------------------------------------------------------
// fenwick_dominance_rank_counter
// Star level counter: a binary indexed tree of x counts gives each placed
// star the number of earlier stars at or left of it, and a level histogram
// records how many stars have each level.
// ---------------------------------------------------------------------------
//  Channel      Direction  Handshake          Carries
//  i_star_req   in         valid/ready        action, x_coord, level_index
//  o_star_rsp   out        valid/ready        star_level, level_count, error
//  APB          in         psel/penable       max_x_in_use at byte address 0
//
//  A placement runs the prefix walk, the histogram read and bump, and the
//  update walk; the single read port of the tree RAM walks one tree node
//  per cycle. A histogram read and a rejected star skip the walks.
//  After reset a clearing pass over max(tree depth, histogram depth)
//  addresses, 1024 by default, zeroes both RAMs; no request is taken during it.
//  A finished result sits in the output register, so the next request is
//  taken while the previous result waits on o_star_rsp.ready.
// ---------------------------------------------------------------------------
module fenwick_dominance_rank_counter import fdrc_pkg::*; #(
    parameter int X_RANGE   = 1024,
    parameter int MAX_STARS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fdrc_req_if.sink           i_star_req,
    fdrc_rsp_if.source         o_star_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [X_W-1:0] max_x;
    logic           res_valid;
    logic           res_ready;
    t_result        res;
    logic           r_out_valid;
    t_result        r_out;

    // Configuration register
    fdrc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_max_x (max_x)
    );

    // Sequencer with tree and histogram RAMs
    fdrc_ctrl #(.X_RANGE(X_RANGE), .MAX_STARS(MAX_STARS)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_star_req.valid),
        .o_in_ready    (i_star_req.ready),
        .i_action      (i_star_req.action),
        .i_x_coord     (i_star_req.x_coord),
        .i_level_index (i_star_req.level_index),
        .i_max_x       (max_x),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    // Output register: load when empty or draining
    assign res_ready = !r_out_valid || o_star_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_star_rsp.valid       = r_out_valid;
    assign o_star_rsp.star_level  = r_out.star_level;
    assign o_star_rsp.level_count = r_out.level_count;
    assign o_star_rsp.error       = r_out.error;

endmodule

// ===== verif/fdrc_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fdrc_checker
// Watches the request, result and register channels of the star level
// counter, keeps its own copy of the count tree, the level histogram and
// the x limit, and compares every result with the one it worked out.
// ---------------------------------------------------------------------------
module fdrc_checker import fdrc_pkg::*; #(
    parameter int X_RANGE   = 1024,
    parameter int MAX_STARS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fdrc_req_if                i_req,
    fdrc_rsp_if                i_rsp,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    input  logic [PDATA_W-1:0] i_prdata,
    output int                 o_pending,
    output int                 o_fail_count
);

    // Shadow state of the block
    logic [CNT_OUT_W-1:0] bit_tree [1:X_RANGE];
    logic [CNT_OUT_W-1:0] level_hist [0:MAX_STARS-1];
    int                   placed_count;
    logic [X_W-1:0]       max_x_reg;

    // Results owed for accepted requests, oldest first
    t_result              due_results [$];
    int                   fail_total;

    // Count a failure; show only the first few
    function automatic void log_failure(string msg);
        fail_total++;
        if (fail_total <= 10)
            $display("%t: %s", $realtime, msg);
    endfunction

    // Work out the result of one request and advance the shadow state
    function automatic t_result apply_request(logic act, logic [X_W-1:0] x,
                                              logic [LVL_W-1:0] idx);
        t_result res;
        int      eff_max;
        int      pos;
        int      lvl;
        res = '0;
        eff_max = (int'(max_x_reg) > X_RANGE - 1) ? X_RANGE - 1 : int'(max_x_reg);
        if (act == ACT_READ) begin
            if (int'(idx) < MAX_STARS)
                res.level_count = level_hist[idx];
        end else if (int'(x) > eff_max || placed_count >= MAX_STARS) begin
            res.error = 1'b1;
        end else begin
            // Prefix walk: sum the nodes covering positions 1 .. x+1
            lvl = 0;
            pos = int'(x) + 1;
            while (pos > 0 && pos <= X_RANGE) begin
                lvl += int'(bit_tree[pos]);
                pos -= pos & -pos;
            end
            if (lvl < MAX_STARS)
                level_hist[lvl] = level_hist[lvl] + 1'b1;
            // Update walk stops at the current limit; old stars are not repaired
            pos = int'(x) + 1;
            while (pos > 0 && pos <= eff_max + 1 && pos <= X_RANGE) begin
                bit_tree[pos] = bit_tree[pos] + 1'b1;
                pos += pos & -pos;
            end
            placed_count++;
            res.star_level = LVL_W'(lvl);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int i = 1; i <= X_RANGE; i++)
                bit_tree[i] = '0;
            for (int i = 0; i < MAX_STARS; i++)
                level_hist[i] = '0;
            placed_count = 0;
            max_x_reg    = MAX_X_RESET;
            fail_total   = 0;
            due_results.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            // Compare an accepted result with the oldest one owed
            if (i_rsp.valid && i_rsp.ready) begin
                got.star_level  = i_rsp.star_level;
                got.level_count = i_rsp.level_count;
                got.error       = i_rsp.error;
                if (due_results.size() == 0) begin
                    log_failure($sformatf("result with no request owed: level %0d count %0d error %0b",
                                          got.star_level, got.level_count, got.error));
                end else begin
                    want = due_results.pop_front();
                    if (got !== want)
                        log_failure($sformatf({"result mismatch: expected level %0d count %0d ",
                                               "error %0b, got level %0d count %0d error %0b"},
                                              want.star_level, want.level_count, want.error,
                                              got.star_level, got.level_count, got.error));
                end
            end

            // Predict the result of an accepted request and queue it last
            if (i_req.valid && i_req.ready)
                due_results = {due_results,
                               apply_request(i_req.action, i_req.x_coord,
                                             i_req.level_index)};

            // Track register writes; writes to unknown indexes are dropped
            if (i_psel && i_penable && i_pready && i_pwrite &&
                (i_paddr >> 2) == PADDR_W'(CFG_IDX_MAX_X))
                max_x_reg = i_pwdata[X_W-1:0];

            // Check register reads against the tracked value
            if (i_psel && i_penable && i_pready && !i_pwrite &&
                (i_paddr >> 2) == PADDR_W'(CFG_IDX_MAX_X) &&
                i_prdata !== PDATA_W'(max_x_reg))
                log_failure($sformatf("register read mismatch: expected %0d, got %0d",
                                      max_x_reg, i_prdata));

            o_pending    <= due_results.size();
            o_fail_count <= fail_total;
        end
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives star placements and histogram reads into the rank counter under
// several x limits, with random gaps on both channels and one long result
// stall, fills the star capacity, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module testbench;
    import fdrc_pkg::*;

    localparam int X_RANGE         = 1024;
    localparam int MAX_STARS       = 1024;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_AT     = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_REQS      = 180;
    localparam int TAIL_REQS       = 30;
    localparam logic [PADDR_W-1:0] ADDR_MAX_X  = PADDR_W'(4 * int'(CFG_IDX_MAX_X));
    localparam logic [PADDR_W-1:0] ADDR_UNUSED = ADDR_MAX_X + PADDR_W'(4);
    localparam logic [X_W-1:0]     X_TOP       = X_W'(X_RANGE - 1);

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 pending;
    int                 fail_count;

    // Sender bookkeeping for shaping the stimulus
    logic [X_W-1:0]     cur_max;
    int                 accepted_stars;
    int                 send_burst;

    fdrc_req_if star_req ();
    fdrc_rsp_if star_rsp ();

    fenwick_dominance_rank_counter #(
        .X_RANGE   (X_RANGE),
        .MAX_STARS (MAX_STARS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_star_req (star_req),
        .o_star_rsp (star_rsp),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    fdrc_checker #(
        .X_RANGE   (X_RANGE),
        .MAX_STARS (MAX_STARS)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (star_req),
        .i_rsp        (star_rsp),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One register access: setup cycle, then access until pready
    task automatic apb_access(logic wr, logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the x limit with junk in the unused bits, then read it back
    task automatic set_max(logic [X_W-1:0] value);
        apb_access(1'b1, ADDR_MAX_X, {PDATA_W'($urandom()) >> X_W << X_W} | PDATA_W'(value));
        cur_max = value;
        apb_access(1'b0, ADDR_MAX_X, '0);
    endtask

    // Offer one request after a random gap and hold it until taken
    task automatic send_req(logic act, logic [X_W-1:0] x, logic [LVL_W-1:0] idx);
        int gap;
        if (send_burst > 0) begin
            gap = 0;
            send_burst--;
        end else begin
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 19) == 0)
                send_burst = $urandom_range(10, 50);
        end
        if (gap > 0) begin
            star_req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        star_req.valid       <= 1'b1;
        star_req.action      <= act;
        star_req.x_coord     <= x;
        star_req.level_index <= idx;
        do @(posedge i_clk); while (!star_req.ready);
        if (act == ACT_PLACE && x <= cur_max && accepted_stars < MAX_STARS)
            accepted_stars++;
    endtask

    // Mostly placements inside the limit and reads of levels in use
    task automatic random_req();
        logic             act;
        logic [X_W-1:0]   x;
        logic [LVL_W-1:0] idx;
        int               sel;
        int               hi;
        act = ($urandom_range(0, 99) < 80) ? ACT_PLACE : ACT_READ;
        sel = $urandom_range(0, 99);
        if (sel < 75)
            x = X_W'($urandom_range(0, int'(cur_max)));
        else if (sel < 90 && cur_max < X_TOP)
            x = X_W'($urandom_range(int'(cur_max) + 1, int'(X_TOP)));
        else
            x = X_W'($urandom());
        hi = (accepted_stars > MAX_STARS - 1) ? MAX_STARS - 1 : accepted_stars;
        if ($urandom_range(0, 99) < 70)
            idx = LVL_W'($urandom_range(0, hi));
        else
            idx = LVL_W'($urandom());
        send_req(act, x, idx);
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic drain();
        star_req.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Result side: random ready gaps, stretches without gaps, one long stall
    initial begin : result_sink
        int gap;
        int burst;
        int taken;
        burst = 0;
        taken = 0;
        star_rsp.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (taken == HOLD_OFF_AT) begin
                gap = HOLD_OFF_CYCLES;
            end else if (burst > 0) begin
                gap = 0;
                burst--;
            end else begin
                gap = $urandom_range(0, 3);
                if ($urandom_range(0, 19) == 0)
                    burst = $urandom_range(10, 50);
            end
            if (gap > 0) begin
                star_rsp.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            star_rsp.ready <= 1'b1;
            do @(posedge i_clk); while (!star_rsp.valid);
            taken++;
        end
    end

    // Abort a hung run
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("fenwick_dominance_rank_counter test failed");
        $finish;
    end

    initial begin : stimulus
        logic [X_W-1:0] phase_max [RANDOM_PHASES];
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        star_req.valid       <= 1'b0;
        star_req.action      <= ACT_PLACE;
        star_req.x_coord     <= '0;
        star_req.level_index <= '0;
        cur_max        = MAX_X_RESET;
        accepted_stars = 0;
        send_burst     = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full range: empty reads, both x extremes, repeated x, mixed bit patterns
        set_max(X_TOP);
        send_req(ACT_READ,  '0,       '0);
        send_req(ACT_READ,  10'h3FF,  10'h3FF);
        send_req(ACT_PLACE, '0,       10'h3FF);
        send_req(ACT_PLACE, X_TOP,    '0);
        send_req(ACT_PLACE, '0,       '0);
        send_req(ACT_PLACE, 10'h155,  10'h2AA);
        send_req(ACT_PLACE, 10'h2AA,  10'h155);
        send_req(ACT_READ,  10'h155,  10'h155);
        send_req(ACT_READ,  10'h2AA,  10'h2AA);
        send_req(ACT_READ,  '0,       10'd1);
        send_req(ACT_PLACE, X_TOP,    '0);
        drain();

        // Limit at zero; a write to an unknown index must change nothing
        set_max('0);
        apb_access(1'b1, ADDR_UNUSED, '1);
        send_req(ACT_PLACE, '0,       '0);
        send_req(ACT_PLACE, 10'd1,    '0);
        send_req(ACT_PLACE, X_TOP,    '0);
        send_req(ACT_READ,  '0,       '0);
        drain();

        // Mid limit: accept at the limit, reject just above it
        set_max(10'd300);
        send_req(ACT_PLACE, 10'd300,  '0);
        send_req(ACT_PLACE, 10'd301,  '0);
        send_req(ACT_PLACE, X_TOP,    '0);
        send_req(ACT_READ,  '0,       10'h3FF);
        drain();

        // Random phases, each under its own limit
        phase_max[0] = X_TOP;
        phase_max[1] = X_W'($urandom_range(1, int'(X_TOP) - 1));
        phase_max[2] = X_TOP;
        phase_max[3] = '0;
        phase_max[4] = X_W'($urandom_range(1, int'(X_TOP) - 1));
        phase_max[5] = X_TOP;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_max(phase_max[p]);
            repeat (PHASE_REQS) random_req();
            drain();
        end

        // Fill the star capacity, then keep going past it
        set_max(X_TOP);
        while (accepted_stars < MAX_STARS)
            random_req();
        repeat (TAIL_REQS) random_req();
        drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("fenwick_dominance_rank_counter test passed");
        else
            $display("fenwick_dominance_rank_counter test failed");
        $finish;
    end

endmodule

// ===== fenwick_dominance_rank_counter.f =====
+incdir+sv
sv/fdrc_pkg.sv
sv/fdrc_req_if.sv
sv/fdrc_rsp_if.sv
sv/fdrc_ram.sv
sv/fdrc_cfg.sv
sv/fdrc_ctrl.sv
sv/fenwick_dominance_rank_counter.sv
verif/fdrc_checker.sv
verif/testbench.sv
